// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, clocked on clk with async reset arst_n
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge outside reset
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`endif

// ----- hdl/ppu_pkg.sv -----
// ---------------------------------------------------------------------------
// ppu_pkg
// shared types and constants of the packed pattern unpacker
// ---------------------------------------------------------------------------
package ppu_pkg;

	localparam int ROWS_DEF  = 64;
	localparam int CHANNELS  = 32;
	localparam int QDEPTH    = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 8;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_NOTE  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_INSTR = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_VOL   = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_EMPTY_EFF   = 2'd3;

	localparam logic [7:0] RST_EMPTY_NOTE  = 8'd255;
	localparam logic [7:0] RST_EMPTY_INSTR = 8'd0;
	localparam logic [7:0] RST_EMPTY_VOL   = 8'd255;
	localparam logic [7:0] RST_EMPTY_EFF   = 8'd0;

	// presence flags of a cell
	localparam int FL_NOTE = 0;
	localparam int FL_VOL  = 1;
	localparam int FL_EFF  = 2;

	// record passed from parser to output stage
	typedef struct packed {
		logic       kind;
		logic [5:0] row;
		logic [4:0] channel;
		logic [2:0] flags;
		logic [7:0] note;
		logic [7:0] instrument;
		logic [7:0] volume;
		logic [7:0] effect;
		logic [7:0] effect_value;
	} ppu_rec_t;

	// queue status toward the parser and output stage
	typedef struct packed {
		logic full;
		logic empty;
	} ppu_qstat_t;

endpackage

// ----- hdl/ppu_front.sv -----
// ---------------------------------------------------------------------------
// ppu_front
// byte parser: tracks pattern phase, rows and cell fields, emits records
// ---------------------------------------------------------------------------
module ppu_front import ppu_pkg::*; #(
	parameter int ROWS = ROWS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       accept,
	input  logic [7:0] data_byte,
	input  logic       first_byte,
	output logic       wr,
	output ppu_rec_t   wr_rec
);

	localparam int RW = $clog2(ROWS + 1);

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_SIZE2  = 3'd1;
	localparam logic [2:0] PH_MASTER = 3'd2;
	localparam logic [2:0] PH_NOTE   = 3'd3;
	localparam logic [2:0] PH_INSTR  = 3'd4;
	localparam logic [2:0] PH_VOL    = 3'd5;
	localparam logic [2:0] PH_EFF    = 3'd6;
	localparam logic [2:0] PH_EFFVAL = 3'd7;

	localparam logic [1:0] FROM_NOTE = 2'd0;
	localparam logic [1:0] FROM_VOL  = 2'd1;
	localparam logic [1:0] FROM_EFF  = 2'd2;

	logic [2:0]    phase_q, phase_nxt;
	logic [RW-1:0] row_q, row_nxt, row_inc;
	logic [4:0]    chan_q, chan_nxt;
	logic [2:0]    flags_q, flags_nxt;
	logic [7:0]    note_q, instr_q, vol_q, eff_q, effval_q;
	logic [7:0]    note_nxt, instr_nxt, vol_nxt, eff_nxt, effval_nxt;
	logic          cell_done, end_mk, chan_ok;

	// next phase after a field group, or master when the cell is complete
	function automatic logic [2:0] adv(input logic [2:0] fl, input logic [1:0] from);
		logic [2:0] ph;
		ph = PH_MASTER;
		if (fl[FL_EFF])
			ph = PH_EFF;
		if (fl[FL_VOL] && (from == FROM_NOTE || from == FROM_VOL))
			ph = PH_VOL;
		if (fl[FL_NOTE] && from == FROM_NOTE)
			ph = PH_NOTE;
		return ph;
	endfunction

	assign row_inc = row_q + 1'b1;

	always_comb begin
		phase_nxt  = phase_q;
		row_nxt    = row_q;
		chan_nxt   = chan_q;
		flags_nxt  = flags_q;
		note_nxt   = note_q;
		instr_nxt  = instr_q;
		vol_nxt    = vol_q;
		eff_nxt    = eff_q;
		effval_nxt = effval_q;
		cell_done  = 1'b0;
		end_mk     = 1'b0;
		if (accept) begin
			if (first_byte) begin
				phase_nxt = PH_SIZE2;
				row_nxt   = '0;
				chan_nxt  = '0;
				flags_nxt = '0;
			end else begin
				case (phase_q)
					PH_IDLE: begin
					end
					PH_SIZE2: begin
						phase_nxt = PH_MASTER;
					end
					PH_MASTER: begin
						if (data_byte == 8'd0) begin
							row_nxt = row_inc;
							if (row_inc == RW'(ROWS)) begin
								phase_nxt = PH_IDLE;
								end_mk    = 1'b1;
							end
						end else begin
							chan_nxt  = data_byte[4:0];
							flags_nxt = data_byte[7:5];
							phase_nxt = adv(data_byte[7:5], FROM_NOTE);
							cell_done = (phase_nxt == PH_MASTER);
						end
					end
					PH_NOTE: begin
						note_nxt  = data_byte;
						phase_nxt = PH_INSTR;
					end
					PH_INSTR: begin
						instr_nxt = data_byte;
						phase_nxt = adv(flags_q, FROM_VOL);
						cell_done = (phase_nxt == PH_MASTER);
					end
					PH_VOL: begin
						vol_nxt   = data_byte;
						phase_nxt = adv(flags_q, FROM_EFF);
						cell_done = (phase_nxt == PH_MASTER);
					end
					PH_EFF: begin
						eff_nxt   = data_byte;
						phase_nxt = PH_EFFVAL;
					end
					PH_EFFVAL: begin
						effval_nxt = data_byte;
						phase_nxt  = PH_MASTER;
						cell_done  = 1'b1;
					end
					default: begin
						phase_nxt = PH_IDLE;
					end
				endcase
			end
		end
	end

	assign chan_ok = ({1'b0, chan_nxt} < 6'(CHANNELS));
	assign wr      = end_mk || (cell_done && chan_ok);

	always_comb begin
		wr_rec.kind         = end_mk;
		wr_rec.row          = end_mk ? 6'd0 : 6'(row_q);
		wr_rec.channel      = end_mk ? 5'd0 : chan_nxt;
		wr_rec.flags        = end_mk ? 3'd0 : flags_nxt;
		wr_rec.note         = note_nxt;
		wr_rec.instrument   = instr_nxt;
		wr_rec.volume       = vol_nxt;
		wr_rec.effect       = eff_nxt;
		wr_rec.effect_value = effval_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			row_q   <= '0;
			chan_q  <= '0;
			flags_q <= '0;
		end else begin
			phase_q <= phase_nxt;
			row_q   <= row_nxt;
			chan_q  <= chan_nxt;
			flags_q <= flags_nxt;
		end
	end

	always_ff @(posedge clk) begin
		note_q   <= note_nxt;
		instr_q  <= instr_nxt;
		vol_q    <= vol_nxt;
		eff_q    <= eff_nxt;
		effval_q <= effval_nxt;
	end

endmodule

// ----- hdl/ppu_fifo.sv -----
// ---------------------------------------------------------------------------
// ppu_fifo
// short record queue between parser and output stage
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module ppu_fifo import ppu_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       wr,
	input  ppu_rec_t   wr_rec,
	input  logic       rd,
	output ppu_rec_t   rd_rec,
	output ppu_qstat_t stat
);

	localparam int PW = $clog2(QDEPTH);
	localparam int CW = $clog2(QDEPTH + 1);

	ppu_rec_t      mem [QDEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [CW-1:0] cnt_q;

	assign stat.full  = (cnt_q == CW'(QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rd_rec     = mem[rp_q];

	always_ff @(posedge clk) begin
		if (wr)
			mem[wp_q] <= wr_rec;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr)
				wp_q <= (wp_q == PW'(QDEPTH - 1)) ? '0 : wp_q + 1'b1;
			if (rd)
				rp_q <= (rp_q == PW'(QDEPTH - 1)) ? '0 : rp_q + 1'b1;
			case ({wr, rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	`ASSERT_NEVER(a_no_overflow, wr && stat.full, "record written into full queue")
	`ASSERT_NEVER(a_no_underflow, rd && stat.empty, "record read from empty queue")
	`ASSERT_CLK(a_ptr_gap, wp_q == PW'(rp_q + PW'(cnt_q)), "queue pointers and count disagree")

endmodule

// ----- hdl/ppu_back.sv -----
// ---------------------------------------------------------------------------
// ppu_back
// output stage: fills absent fields from empty regs or zero, holds result
// ---------------------------------------------------------------------------
module ppu_back import ppu_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  ppu_qstat_t           qstat,
	input  ppu_rec_t             rec,
	output logic                 rd,
	input  logic                 pop,
	output logic                 empty,
	output logic                 kind,
	output logic [5:0]           row,
	output logic [4:0]           channel,
	output logic [7:0]           note,
	output logic [7:0]           instrument,
	output logic [7:0]           volume,
	output logic [7:0]           effect,
	output logic [7:0]           effect_value
);

	logic [7:0] e_note_q, e_instr_q, e_vol_q, e_eff_q;
	logic       valid_q;
	logic       kind_q;
	logic [5:0] row_q;
	logic [4:0] chan_q;
	logic [7:0] note_q, instr_q, vol_q, eff_q, effval_q;
	logic       is_cell;

	assign rd      = !qstat.empty && (!valid_q || pop);
	assign is_cell = !rec.kind;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e_note_q  <= RST_EMPTY_NOTE;
			e_instr_q <= RST_EMPTY_INSTR;
			e_vol_q   <= RST_EMPTY_VOL;
			e_eff_q   <= RST_EMPTY_EFF;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_EMPTY_NOTE:  e_note_q  <= cfg_data;
				CFG_EMPTY_INSTR: e_instr_q <= cfg_data;
				CFG_EMPTY_VOL:   e_vol_q   <= cfg_data;
				CFG_EMPTY_EFF:   e_eff_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (rd)
			valid_q <= 1'b1;
		else if (pop)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (rd) begin
			kind_q   <= rec.kind;
			row_q    <= rec.row;
			chan_q   <= rec.channel;
			if (is_cell) begin
				note_q   <= rec.flags[FL_NOTE] ? rec.note : e_note_q;
				instr_q  <= rec.flags[FL_NOTE] ? rec.instrument : e_instr_q;
				vol_q    <= rec.flags[FL_VOL] ? rec.volume : e_vol_q;
				eff_q    <= rec.flags[FL_EFF] ? rec.effect : e_eff_q;
				effval_q <= rec.flags[FL_EFF] ? rec.effect_value : 8'd0;
			end else begin
				note_q   <= 8'd0;
				instr_q  <= 8'd0;
				vol_q    <= 8'd0;
				eff_q    <= 8'd0;
				effval_q <= 8'd0;
			end
		end
	end

	assign empty        = !valid_q;
	assign kind         = kind_q;
	assign row          = row_q;
	assign channel      = chan_q;
	assign note         = note_q;
	assign instrument   = instr_q;
	assign volume       = vol_q;
	assign effect       = eff_q;
	assign effect_value = effval_q;

endmodule

// ----- hdl/packed_pattern_unpacker_top.sv -----
// ---------------------------------------------------------------------------
// packed_pattern_unpacker_top
// byte-serial decoder of packed tracker patterns into cells and end markers
// ---------------------------------------------------------------------------
// Takes one byte per clock while full is low; each accepted byte advances the
// parser state registers. A finished cell or end marker is written into a
// 4-entry record queue as its last byte is accepted, and moves into the result
// registers once they are empty or being popped. full follows the record queue
// alone: it rises only when four records wait behind an untaken result, so with
// pop held high the block runs at one byte per cycle indefinitely.
module packed_pattern_unpacker_top import ppu_pkg::*; #(
	parameter int ROWS = ROWS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  logic [7:0]           data_byte,
	input  logic                 first_byte,
	output logic                 empty,
	input  logic                 pop,
	output logic                 kind,
	output logic [5:0]           row,
	output logic [4:0]           channel,
	output logic [7:0]           note,
	output logic [7:0]           instrument,
	output logic [7:0]           volume,
	output logic [7:0]           effect,
	output logic [7:0]           effect_value,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	logic       accept;
	logic       q_wr, q_rd;
	ppu_rec_t   wr_rec, rd_rec;
	ppu_qstat_t qstat;

	assign full   = qstat.full;
	assign accept = push && !qstat.full;

	ppu_front #(.ROWS(ROWS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.data_byte  (data_byte),
		.first_byte (first_byte),
		.wr         (q_wr),
		.wr_rec     (wr_rec)
	);

	ppu_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (q_wr),
		.wr_rec (wr_rec),
		.rd     (q_rd),
		.rd_rec (rd_rec),
		.stat   (qstat)
	);

	ppu_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.qstat        (qstat),
		.rec          (rd_rec),
		.rd           (q_rd),
		.pop          (pop),
		.empty        (empty),
		.kind         (kind),
		.row          (row),
		.channel      (channel),
		.note         (note),
		.instrument   (instrument),
		.volume       (volume),
		.effect       (effect),
		.effect_value (effect_value)
	);

endmodule
